// ===== hw/rtl/crc32_frame_seal_and_check_core_macros.svh =====
// Assertion macros for the CRC-32 frame seal and check core.
// Used by the top level; assertions compile out when SYNTHESIS is defined.
`ifndef CRC32_FRAME_SEAL_AND_CHECK_CORE_MACROS_SVH
`define CRC32_FRAME_SEAL_AND_CHECK_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked on every rising clk edge outside reset
`define CRCFC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crcfc check failed");

// Next-cycle implication checked on every rising clk edge outside reset
`define CRCFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crcfc check failed");

`else

`define CRCFC_ASSERT_IMP(label, ante, cons)

`define CRCFC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/crcfc_pkg.sv =====
// Package for the CRC-32 frame seal and check core: status codes,
// frame constants and the byte-wide CRC-32 update. No dependencies.
`timescale 1ns / 1ps

package crcfc_pkg;

    // Frame layout
    localparam int HEADER_BYTES  = 16;
    localparam int ID_OFFSET     = 0;
    localparam int TRAILER_BYTES = 4;

    localparam logic [15:0] MIN_FRAME_LEN = 16'(HEADER_BYTES + TRAILER_BYTES);
    localparam logic [15:0] ID_FIRST      = 16'(ID_OFFSET);
    localparam logic [15:0] ID_END        = 16'(ID_OFFSET + 4);
    localparam logic [15:0] TRAILER_LEN   = 16'(TRAILER_BYTES);
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // CRC-32 (reflected)
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Request direction
    localparam logic ACT_TX = 1'b0;
    localparam logic ACT_RX = 1'b1;

    // Result kind
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Trailer sequencing: phase 0 sends the data byte, 1..4 send the CRC
    localparam logic [2:0] PH_DATA     = 3'd0;
    localparam logic [2:0] PH_TRL_LAST = 3'd4;

    typedef enum logic [1:0] {
        ST_SHORT   = 2'd0,
        ST_CRC_BAD = 2'd1,
        ST_OWN     = 2'd2,
        ST_ACCEPT  = 2'd3
    } status_t;

    // Receive-side step result handed to the top level
    typedef struct packed {
        logic [31:0] crc_next;
        status_t     status;
        logic [15:0] frame_len;
    } rx_res_t;

    // One byte through the reflected CRC-32, bit at a time (pure XOR network)
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/crcfc_in_if.sv =====
// Input channel interface: valid/ready with one frame byte per request.
// No package dependency.
`timescale 1ns / 1ps

interface crcfc_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, action, data_byte, last, input ready);
    modport sink   (input valid, action, data_byte, last, output ready);
endinterface

// ===== hw/rtl/crcfc_out_if.sv =====
// Output channel interface: valid/ready carrying transmit bytes and receive verdicts.
// No package dependency.
`timescale 1ns / 1ps

interface crcfc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [1:0]  status;
    logic [15:0] frame_length;

    modport source (output valid, kind, out_byte, out_last, status, frame_length,
                    input ready);
    modport sink   (input valid, kind, out_byte, out_last, status, frame_length,
                    output ready);
endinterface

// ===== hw/rtl/crcfc_rx_track.sv =====
// Receive-side tracker: trailer window, length counter, sender ID capture
// and verdict. Uses crcfc_pkg.
`timescale 1ns / 1ps

module crcfc_rx_track (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  last,
    input  logic [31:0]           crc_cur,
    input  logic [31:0]           own_id,
    output crcfc_pkg::rx_res_t    res
);
    import crcfc_pkg::*;

    logic [31:0] window_reg, window_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] crc_fed;
    logic [15:0] id_rel;
    logic        id_hit;
    status_t     status;

    // Byte leaving the window goes into the CRC once the window is full
    assign crc_fed     = (count_reg >= TRAILER_LEN) ? crc_byte(crc_cur, window_reg[7:0])
                                                    : crc_cur;
    assign window_next = {data_byte, window_reg[31:8]};
    assign count_next  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'd1;

    // Sender ID capture, least significant byte first
    assign id_rel = count_reg - ID_FIRST;
    assign id_hit = (count_reg >= ID_FIRST) && (count_reg < ID_END);

    always_comb
    begin
        id_next = id_reg;
        if (id_hit)
        begin
            case (id_rel[1:0])
                2'd0:    id_next[7:0]   = data_byte;
                2'd1:    id_next[15:8]  = data_byte;
                2'd2:    id_next[23:16] = data_byte;
                2'd3:    id_next[31:24] = data_byte;
                default: id_next        = id_reg;
            endcase
        end
    end

    // Verdict, in priority order
    always_comb
    begin
        if (count_next < MIN_FRAME_LEN)
            status = ST_SHORT;
        else if (~crc_fed != window_next)
            status = ST_CRC_BAD;
        else if (id_next == own_id)
            status = ST_OWN;
        else
            status = ST_ACCEPT;
    end

    assign res.crc_next  = last ? CRC_INIT : crc_fed;
    assign res.status    = status;
    assign res.frame_len = count_next;

    // State update; frame end returns everything to reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
            id_reg     <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                window_reg <= '0;
                count_reg  <= '0;
                id_reg     <= '0;
            end
            else
            begin
                window_reg <= window_next;
                count_reg  <= count_next;
                id_reg     <= id_next;
            end
        end
    end

endmodule

// ===== hw/rtl/crc32_frame_seal_and_check_core.sv =====
// A request is captured in the input register; its first result is then loaded
// into the output register.
// Throughput: one byte per cycle while the output accepts; a transmit frame end
// holds the input register while the four CRC trailer bytes go out, one per cycle.
// Reset (rst_n, async, active low): CRC all ones, window, count, ID and own_id zero.
`timescale 1ns / 1ps
`include "crc32_frame_seal_and_check_core_macros.svh"

module crc32_frame_seal_and_check_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [31:0]   cfg_wdata,
    crcfc_in_if.sink      in_ch,
    crcfc_out_if.source   out_ch
);
    import crcfc_pkg::*;

    // Input register (also the skid stage)
    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic [2:0]  phase_reg;

    // Output register
    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic [1:0]  out_status_reg;
    logic [15:0] out_len_reg;

    logic [31:0] crc_reg, crc_next;
    logic [31:0] own_id_reg;

    logic        out_free;
    logic        is_tx;
    logic        emit;
    logic        retire;
    logic        rx_step;
    logic        tx_go;
    logic [31:0] crc_tx_next;
    logic [31:0] crc_final;
    logic [1:0]  trl_sel;
    logic [7:0]  trl_byte;
    rx_res_t     rx_res;

    // Handshake control
    assign out_free = !out_valid_reg || out_ch.ready;
    assign is_tx    = (s1_action_reg == ACT_TX);
    assign tx_go    = s1_valid_reg && is_tx && out_free;
    assign emit     = s1_valid_reg && out_free && (is_tx || s1_last_reg);
    assign rx_step  = s1_valid_reg && !is_tx && (!s1_last_reg || out_free);
    assign retire   = rx_step ||
                      (tx_go && (!s1_last_reg || phase_reg == PH_TRL_LAST));
    assign in_ch.ready = !s1_valid_reg || retire;

    // Transmit CRC and trailer byte select
    assign crc_tx_next = crc_byte(crc_reg, s1_byte_reg);
    assign crc_final   = ~crc_reg;
    assign trl_sel     = 2'(phase_reg - 3'd1);

    always_comb
    begin
        case (trl_sel)
            2'd0:    trl_byte = crc_final[7:0];
            2'd1:    trl_byte = crc_final[15:8];
            2'd2:    trl_byte = crc_final[23:16];
            2'd3:    trl_byte = crc_final[31:24];
            default: trl_byte = crc_final[7:0];
        endcase
    end

    // Receive tracker
    crcfc_rx_track u_rx (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (rx_step),
        .data_byte (s1_byte_reg),
        .last      (s1_last_reg),
        .crc_cur   (crc_reg),
        .own_id    (own_id_reg),
        .res       (rx_res)
    );

    // Shared CRC register next value
    always_comb
    begin
        crc_next = crc_reg;
        if (tx_go)
        begin
            if (phase_reg == PH_DATA)
                crc_next = crc_tx_next;
            else if (phase_reg == PH_TRL_LAST)
                crc_next = CRC_INIT;
        end
        else if (rx_step)
            crc_next = rx_res.crc_next;
    end

    // Configuration and CRC state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= '0;
            crc_reg    <= CRC_INIT;
        end
        else
        begin
            if (cfg_we)
                own_id_reg <= cfg_wdata;
            crc_reg <= crc_next;
        end
    end

    // Input register and trailer phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= PH_DATA;
        end
        else
        begin
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (tx_go && s1_last_reg)
                phase_reg <= (phase_reg == PH_TRL_LAST) ? PH_DATA : phase_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_action_reg <= in_ch.action;
            s1_byte_reg   <= in_ch.data_byte;
            s1_last_reg   <= in_ch.last;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (is_tx)
            begin
                out_kind_reg   <= KIND_DATA;
                out_byte_reg   <= (phase_reg == PH_DATA) ? s1_byte_reg : trl_byte;
                out_last_reg   <= (phase_reg == PH_TRL_LAST);
                out_status_reg <= ST_SHORT;
                out_len_reg    <= '0;
            end
            else
            begin
                out_kind_reg   <= KIND_VERDICT;
                out_byte_reg   <= '0;
                out_last_reg   <= 1'b1;
                out_status_reg <= rx_res.status;
                out_len_reg    <= rx_res.frame_len;
            end
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.kind         = out_kind_reg;
    assign out_ch.out_byte     = out_byte_reg;
    assign out_ch.out_last     = out_last_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.frame_length = out_len_reg;

    // Checks
    `CRCFC_ASSERT_IMP(a_phase_only_tx_last, phase_reg != PH_DATA, s1_valid_reg && is_tx && s1_last_reg)
    `CRCFC_ASSERT_IMP(a_verdict_is_last, out_valid_reg && out_kind_reg == KIND_VERDICT, out_last_reg)
    `CRCFC_ASSERT_NEXT(a_crc_reinit, tx_go && phase_reg == PH_TRL_LAST, crc_reg == CRC_INIT)

endmodule

// ===== tb/tb.sv =====
// Testbench for crc32_frame_seal_and_check_core: checks sealed transmit frames with a CRC-32
// trailer and receive verdicts against a byte-level predictor.
// Depends on crcfc_pkg, crcfc_in_if, crcfc_out_if and the core itself.
`timescale 1ns / 1ps

module tb;
    import crcfc_pkg::*;

    localparam int IDLE_PCT    = 21;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic       action;
        logic [7:0] data;
        logic       last;
    } frame_req_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  octet;
        logic        fin;
        status_t     status;
        logic [15:0] length;
    } frame_res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [31:0] cfg_wdata;

    crcfc_in_if  in_ch();
    crcfc_out_if out_ch();

    crc32_frame_seal_and_check_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Requests waiting to go in, results waiting to come out
    frame_req_t req_queue[$];
    frame_res_t awaited_results[$];

    // Predictor state
    logic [31:0] p_crc;
    logic [31:0] p_window;
    logic [15:0] p_count;
    logic [31:0] p_id;
    logic [31:0] p_own_id;

    int  errors;
    int  cycles;
    int  queued_items;
    bit  calm;
    bit  took;

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Reflected CRC-32, one data bit per iteration, LSB first
    function automatic logic [31:0] crc32_next(logic [31:0] state, logic [7:0] octet);
        logic fb;
        for (int j = 0; j < 8; j++)
        begin
            fb = state[0] ^ octet[j];
            state = state >> 1;
            if (fb)
                state = state ^ CRC_POLY;
        end
        return state;
    endfunction

    function automatic void note_result(logic kind, logic [7:0] octet, logic fin,
                                        status_t st, logic [15:0] len);
        frame_res_t r;
        r.kind   = kind;
        r.octet  = octet;
        r.fin    = fin;
        r.status = st;
        r.length = len;
        awaited_results.push_back(r);
    endfunction

    // Expected results of one accepted request
    function automatic void predict_frame_step(logic action, logic [7:0] b, logic last);
        logic [31:0] sealed;
        status_t     st;
        int          sh;
        if (action == ACT_TX)
        begin
            p_crc = crc32_next(p_crc, b);
            note_result(KIND_DATA, b, 1'b0, ST_SHORT, 16'd0);
            if (last)
            begin
                sealed = ~p_crc;
                for (int k = 0; k < 4; k++)
                    note_result(KIND_DATA, sealed[8*k +: 8], k == 3, ST_SHORT, 16'd0);
                p_crc = CRC_INIT;
            end
        end
        else
        begin
            // oldest window byte enters the CRC once the trailer window is full
            if (p_count >= TRAILER_LEN)
                p_crc = crc32_next(p_crc, p_window[7:0]);
            p_window = {b, p_window[31:8]};
            if (p_count >= ID_FIRST && p_count < ID_END)
            begin
                sh = int'(p_count - ID_FIRST);
                p_id[8*sh +: 8] = b;
            end
            if (p_count != COUNT_MAX)
                p_count = p_count + 16'd1;
            if (last)
            begin
                if (p_count < MIN_FRAME_LEN)
                    st = ST_SHORT;
                else if (~p_crc != p_window)
                    st = ST_CRC_BAD;
                else if (p_id == p_own_id)
                    st = ST_OWN;
                else
                    st = ST_ACCEPT;
                note_result(KIND_VERDICT, 8'd0, 1'b1, st, p_count);
                p_crc    = CRC_INIT;
                p_window = '0;
                p_count  = '0;
                p_id     = '0;
            end
        end
    endfunction

    // Request queue fillers
    task automatic queue_byte(logic action, logic [7:0] b, logic last);
        frame_req_t r;
        r.action = action;
        r.data   = b;
        r.last   = last;
        req_queue.push_back(r);
        queued_items++;
    endtask

    task automatic queue_tx_frame(int len);
        for (int k = 0; k < len; k++)
            queue_byte(ACT_TX, 8'($urandom), k == len - 1);
    endtask

    // Receive frame: ID at the header offset, trailer sealed over the body
    task automatic queue_rx_frame(int total, logic [31:0] id, bit corrupt);
        logic [7:0]  octets[$];
        logic [7:0]  b;
        logic [31:0] c;
        int          body_len;
        int          pos;
        body_len = (total >= 4) ? total - 4 : total;
        c = CRC_INIT;
        for (int k = 0; k < body_len; k++)
        begin
            if (k >= ID_OFFSET && k < ID_OFFSET + 4)
                b = id[8*(k - ID_OFFSET) +: 8];
            else
                b = 8'($urandom);
            c = crc32_next(c, b);
            octets.push_back(b);
        end
        if (total >= 4)
        begin
            c = ~c;
            for (int k = 0; k < 4; k++)
                octets.push_back(c[8*k +: 8]);
        end
        if (corrupt)
        begin
            pos = $urandom_range(total - 1);
            octets[pos] = octets[pos] ^ (8'd1 << $urandom_range(7));
        end
        for (int k = 0; k < total; k++)
            queue_byte(ACT_RX, octets[k], k == total - 1);
    endtask

    // Random mix of frames, mostly well formed
    task automatic queue_random(int n);
        int start;
        int pick;
        int len;
        start = queued_items;
        while (queued_items - start < n)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                queue_rx_frame($urandom_range(20, 28), $urandom, 1'b0);
            else if (pick < 45)
                queue_rx_frame($urandom_range(20, 28), p_own_id, 1'b0);
            else if (pick < 60)
                queue_rx_frame($urandom_range(20, 28), $urandom, 1'b1);
            else if (pick < 70)
                queue_rx_frame($urandom_range(1, 19), $urandom, 1'b0);
            else if (pick < 92)
                queue_tx_frame($urandom_range(1, 12));
            else
            begin
                // noise: random direction and frame ends
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    queue_byte(1'($urandom), 8'($urandom), $urandom_range(7) == 0);
            end
        end
    endtask

    task automatic wait_drained();
        while (req_queue.size() != 0 || awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_own_id(logic [31:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        p_own_id = v;
    endtask

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Driver: acceptance feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            predict_frame_step(in_ch.action, in_ch.data_byte, in_ch.last);
            req_queue.pop_front();
            took = 1'b1;
        end
    end

    // Driver: present the next request on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || took)
        begin
            took = 1'b0;
            if (req_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                in_ch.valid     <= 1'b1;
                in_ch.action    <= req_queue[0].action;
                in_ch.data_byte <= req_queue[0].data;
                in_ch.last      <= req_queue[0].last;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        frame_res_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected result: kind %0d byte %02h last %0d status %0d len %0d",
                             out_ch.kind, out_ch.out_byte, out_ch.out_last,
                             out_ch.status, out_ch.frame_length);
                errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (want.kind !== out_ch.kind || want.octet !== out_ch.out_byte ||
                    want.fin !== out_ch.out_last || want.status !== out_ch.status ||
                    want.length !== out_ch.frame_length)
                begin
                    if (errors < 10)
                    begin
                        $display("mismatch: exp kind %0d byte %02h last %0d status %0d len %0d",
                                 want.kind, want.octet, want.fin, want.status, want.length);
                        $display("          got kind %0d byte %02h last %0d status %0d len %0d",
                                 out_ch.kind, out_ch.out_byte, out_ch.out_last,
                                 out_ch.status, out_ch.frame_length);
                    end
                    errors++;
                end
            end
        end
    end

    // Sequence of phases
    initial
    begin
        in_ch.valid     = 1'b0;
        in_ch.action    = ACT_TX;
        in_ch.data_byte = 8'd0;
        in_ch.last      = 1'b0;
        out_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        rst_n           = 1'b0;
        errors          = 0;
        cycles          = 0;
        queued_items    = 0;
        calm            = 1'b0;
        took            = 1'b0;
        p_crc           = CRC_INIT;
        p_window        = '0;
        p_count         = '0;
        p_id            = '0;
        p_own_id        = '0;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: byte extremes, transmit seals, short receive frames
        queue_byte(ACT_TX, 8'hFF, 1'b1);
        queue_byte(ACT_TX, 8'h00, 1'b0);
        queue_byte(ACT_TX, 8'h5A, 1'b1);
        // one-byte frame: ID never fully seen
        queue_byte(ACT_RX, 8'h00, 1'b1);
        queue_byte(ACT_RX, 8'hFF, 1'b0);
        queue_byte(ACT_RX, 8'h12, 1'b0);
        queue_byte(ACT_RX, 8'h34, 1'b1);
        // transmit frame interleaved in an open receive frame
        queue_byte(ACT_RX, 8'hAB, 1'b0);
        queue_byte(ACT_RX, 8'hCD, 1'b0);
        queue_byte(ACT_TX, 8'h77, 1'b1);
        queue_byte(ACT_RX, 8'hEF, 1'b1);
        // minimum-length frame carrying the reset own_id
        queue_rx_frame(20, 32'h0, 1'b0);
        wait_drained();

        write_own_id(32'hFFFF_FFFF);
        queue_random(80);
        wait_drained();

        // no idling on either side through this phase
        write_own_id($urandom);
        calm = 1'b1;
        queue_random(80);
        wait_drained();
        calm = 1'b0;

        write_own_id(32'h0);
        queue_random(80);
        wait_drained();

        // own frame after an ID change, then a random tail
        write_own_id(32'h8000_0001);
        queue_rx_frame($urandom_range(20, 28), p_own_id, 1'b0);
        queue_random(20);

        while (req_queue.size() != 0 || awaited_results.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
